/* hdl/cbd_pkg.sv */
// cbd_pkg: shared types and constants for the circular buffer deque
// no dependencies; imported by cbd_cell, cbd_chain and circular_buffer_deque

package cbd_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_W-1:0] EMPTY_WORD = 32'h8000_0000;

	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 72;
	localparam int PADDR_W = 3;

	// register index, taken from paddr[PADDR_W-1:2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	// one-hot per accepted beat or capacity write (clear), at most one set
	typedef struct packed {
		logic clear;
		logic shift_in;   // push front: every cell takes its left neighbor
		logic shift_out;  // pop front: every cell takes its right neighbor
		logic append;     // push back: first empty cell takes the word
		logic trim;       // pop back: last full cell goes empty
	} cell_ctl_t;

endpackage

/* hdl/cbd_cell.sv */
// cbd_cell: one slot of the deque chain, holding a word and its occupied bit
// depends on cbd_pkg

module cbd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cbd_pkg::cell_ctl_t        ctl,
	input  logic [cbd_pkg::DATA_W-1:0] push_word,
	input  logic [cbd_pkg::DATA_W-1:0] left_word,
	input  logic                      left_valid,
	input  logic [cbd_pkg::DATA_W-1:0] right_word,
	input  logic                      right_valid,
	output logic [cbd_pkg::DATA_W-1:0] word,
	output logic                      valid
);
	import cbd_pkg::*;

	logic [DATA_W-1:0] word_q;
	logic              valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_in) begin
			valid_q <= left_valid;
		end else if (ctl.shift_out) begin
			valid_q <= right_valid;
		end else if (ctl.append && !valid_q && left_valid) begin
			valid_q <= 1'b1;
		end else if (ctl.trim && valid_q && !right_valid) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_in) begin
			word_q <= left_word;
		end else if (ctl.shift_out) begin
			word_q <= right_word;
		end else if (ctl.append && !valid_q && left_valid) begin
			word_q <= push_word;
		end
	end

	assign word  = word_q;
	assign valid = valid_q;

endmodule

/* hdl/cbd_chain.sv */
// cbd_chain: row of cbd_cell slots in queue order, front in cell 0
// depends on cbd_pkg and cbd_cell; also picks out the rear word

module cbd_chain #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cbd_pkg::cell_ctl_t         ctl,
	input  logic [cbd_pkg::DATA_W-1:0] push_word,
	output logic [cbd_pkg::DATA_W-1:0] front_word,
	output logic [cbd_pkg::DATA_W-1:0] rear_word,
	output logic [DEPTH-1:0]           valid
);
	import cbd_pkg::*;

	logic [DATA_W-1:0] words [DEPTH];
	logic [DATA_W-1:0] rear_terms [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] lw;
		logic              lv;
		logic [DATA_W-1:0] rw;
		logic              rv;

		if (i == 0) begin : g_head
			assign lw = push_word;
			assign lv = 1'b1;
		end else begin : g_mid
			assign lw = words[i-1];
			assign lv = valid[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign rw = '0;
			assign rv = 1'b0;
		end else begin : g_body
			assign rw = words[i+1];
			assign rv = valid[i+1];
		end

		cbd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_word  (push_word),
			.left_word  (lw),
			.left_valid (lv),
			.right_word (rw),
			.right_valid(rv),
			.word       (words[i]),
			.valid      (valid[i])
		);

		// the rear is the one occupied cell whose right neighbor is empty
		assign rear_terms[i] = (valid[i] && !rv) ? words[i] : '0;
	end

	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | rear_terms[i];
		end
	end

	assign front_word = words[0];

endmodule

/* hdl/circular_buffer_deque.sv */
// circular_buffer_deque: top level, stream ports, apb capacity register, result register
// depends on cbd_pkg, cbd_chain, cbd_cell
//
// Double-ended queue of signed 32-bit words. Each input beat on s_* is one
// operation (push front, push back, pop front, pop back, query); every beat
// gives exactly one result beat on m_* with the front and rear words (0x80000000
// when empty), the empty and full flags, and a dropped flag for a push on a
// full queue or a pop on an empty one. Opcodes above query act as a query.
// Words sit in a row of cells in queue order: a push or pop at the front
// shifts the whole row by one place, a push at the back fills the first
// empty cell and a pop at the back empties the last occupied cell only.
// An accepted beat is registered in pend_q, which then loads the result
// register and raises m_tvalid. No new input beat is taken while one is
// pending, since the row must settle before the result register samples it.
// capacity (apb address 0, 1..16, 0 acts as 1, above DEPTH acts as DEPTH) sets
// the full level; writing it empties the queue. Write it only while idle.
// Reset empties the queue and sets capacity to 16. A stalled m_tready holds
// the result and blocks further input beats until it is taken.

module circular_buffer_deque #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [2:0] opcode, [34:3] value, [39:35] zero
	input  logic [cbd_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] front_value, [63:32] rear_value, [64] is_empty, [65] is_full,
	// [66] dropped, [71:67] zero
	output logic [cbd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cbd_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import cbd_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     count_q;
	logic              pend_q;
	logic              pend_drop_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] rear_q;
	logic              empty_q;
	logic              full_q;
	logic              dropped_q;

	logic              cfg_wr;
	logic              s_accept;
	op_t               op;
	logic [DATA_W-1:0] in_value;
	logic [MW-1:0]     cap_m;
	logic [MW-1:0]     count_m;
	logic              is_full_now;
	logic              is_empty_now;
	logic              drop;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] front_word;
	logic [DATA_W-1:0] rear_word;
	logic [DEPTH-1:0]  valid;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready
	                  && (paddr[PADDR_W-1:2] == REG_CAPACITY);
	assign prdata   = (paddr[PADDR_W-1:2] == REG_CAPACITY)
	                  ? {{(32-CAP_W){1'b0}}, capacity_q} : '0;

	assign s_tready = !pend_q && (!out_valid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;
	assign op       = op_t'(s_tdata[2:0]);
	assign in_value = s_tdata[34:3];

	// capacity clamped to 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap_m = MW'(1);
		end else if (MW'(capacity_q) > DEPTH_M) begin
			cap_m = DEPTH_M;
		end else begin
			cap_m = MW'(capacity_q);
		end
	end

	assign count_m      = MW'(count_q);
	assign is_full_now  = (count_m == cap_m);
	assign is_empty_now = (count_q == '0);

	always_comb begin
		ctl  = '0;
		drop = 1'b0;
		if (cfg_wr) begin
			ctl.clear = 1'b1;
		end else if (s_accept) begin
			case (op)
				OP_PUSH_FRONT: begin
					drop         = is_full_now;
					ctl.shift_in = !is_full_now;
				end
				OP_PUSH_BACK: begin
					drop       = is_full_now;
					ctl.append = !is_full_now;
				end
				OP_POP_FRONT: begin
					drop          = is_empty_now;
					ctl.shift_out = !is_empty_now;
				end
				OP_POP_BACK: begin
					drop     = is_empty_now;
					ctl.trim = !is_empty_now;
				end
				default: begin
				end
			endcase
		end
	end

	cbd_chain #(.DEPTH(DEPTH)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.push_word (in_value),
		.front_word(front_word),
		.rear_word (rear_word),
		.valid     (valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				capacity_q <= pwdata[CAP_W-1:0];
				count_q    <= '0;
			end else if (ctl.shift_in || ctl.append) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.shift_out || ctl.trim) begin
				count_q <= count_q - CW'(1);
			end
			pend_q <= s_accept;
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pend_drop_q <= drop;
		end
		// the row has settled in the cycle after the beat, while pend_q is set
		if (pend_q) begin
			front_q   <= is_empty_now ? EMPTY_WORD : front_word;
			rear_q    <= is_empty_now ? EMPTY_WORD : rear_word;
			empty_q   <= is_empty_now;
			full_q    <= is_full_now;
			dropped_q <= pend_drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, dropped_q, full_q, empty_q, rear_q, front_q};

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(count_q))
		else $error("count differs from occupied cells");

	a_count_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_m <= cap_m)
		else $error("count above capacity in use");

	a_front_cell_first: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> valid[0])
		else $error("queue not packed at the front");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> ##1 m_tvalid)
		else $error("result missing after accepted beat");

endmodule
